// ----- rtl/iir_filter_transposed_df2_defines.svh -----
// assertion macros shared by the filter rtl
`ifndef IIR_FILTER_TRANSPOSED_DF2_DEFINES_SVH
`define IIR_FILTER_TRANSPOSED_DF2_DEFINES_SVH

`ifndef ASSERT_OFF
`define IIR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("iir filter assertion failed");
`define IIR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iir filter assertion failed");
`else
`define IIR_ASSERT(lbl, clk, rst, prop)
`define IIR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/iir_tdf2_pkg.sv -----
package iir_tdf2_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_BITS      = 18;
   localparam int COEF_FRAC_BITS = 14;
   localparam int DELAY_BITS     = 48;
   localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_BITS       = DELAY_BITS + 2;
   localparam int TAP_IDX_BITS   = 2;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic OP_FILTER  = 1'b0;
   localparam logic OP_PRELOAD = 1'b1;

   localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COEF_B0 = 3'd0,
      CSR_COEF_B1 = 3'd1,
      CSR_COEF_B2 = 3'd2,
      CSR_COEF_A1 = 3'd3,
      CSR_COEF_A2 = 3'd4
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_ADD,
      ST_SUB
   } ctrl_state_type;

   typedef struct packed {
      logic                          op;
      logic [TAP_IDX_BITS-1:0]       slot;
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic signed [DELAY_BITS-1:0]  preload_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          clipped;
   } rsp_type;

   typedef struct packed {
      logic                    load;
      logic                    mul_en;
      logic                    mul_fb;
      logic [TAP_IDX_BITS-1:0] coef_idx;
      logic                    push;
      logic                    acc_load;
      logic                    tap_write;
      logic [TAP_IDX_BITS-1:0] tap_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dp_status_type;

endpackage

// ----- rtl/iir_tdf2_ctrl.sv -----
`include "iir_filter_transposed_df2_defines.svh"

module iir_tdf2_ctrl #(
   parameter int TAPS = 3
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_op,
   output logic                        req_stall,
   input  iir_tdf2_pkg::dp_status_type status,
   output iir_tdf2_pkg::dp_cmd_type    cmd
);
   import iir_tdf2_pkg::*;

   localparam logic [TAP_IDX_BITS-1:0] LastTap = TAP_IDX_BITS'(TAPS - 2);

   ctrl_state_type          state_ff, state_in;
   logic [TAP_IDX_BITS-1:0] tap_ff, tap_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      tap_in    = tap_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_op == OP_FILTER) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul_en   = 1'b1;
            cmd.coef_idx = '0;
            state_in     = ST_ACC;
         end
         ST_ACC: begin
            if (!status.out_busy) begin
               cmd.push     = 1'b1;
               cmd.mul_en   = 1'b1;
               cmd.coef_idx = TAP_IDX_BITS'(1);
               tap_in       = '0;
               state_in     = ST_ADD;
            end
         end
         ST_ADD: begin
            // carry plus feedforward term, feedback product in flight
            cmd.acc_load = 1'b1;
            cmd.tap_idx  = tap_ff;
            cmd.mul_en   = 1'b1;
            cmd.mul_fb   = 1'b1;
            cmd.coef_idx = tap_ff + TAP_IDX_BITS'(1);
            state_in     = ST_SUB;
         end
         ST_SUB: begin
            cmd.tap_write = 1'b1;
            cmd.tap_idx   = tap_ff;
            cmd.mul_en    = 1'b1;
            cmd.coef_idx  = tap_ff + TAP_IDX_BITS'(2);
            if (tap_ff == LastTap) begin
               state_in = ST_IDLE;
            end else begin
               tap_in   = tap_ff + TAP_IDX_BITS'(1);
               state_in = ST_ADD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `IIR_ASSERT(a_tap_range, clock, reset, (state_ff == ST_ADD || state_ff == ST_SUB) |-> tap_ff <= LastTap)
   `IIR_ASSERT_NEXT(a_push_starts_taps, clock, reset, cmd.push, state_ff == ST_ADD && tap_ff == '0)
   `IIR_ASSERT_NEXT(a_sample_starts, clock, reset, state_ff == ST_IDLE && req_valid && req_op == OP_FILTER, state_ff == ST_MUL)

endmodule

// ----- rtl/iir_tdf2_dp.sv -----
`include "iir_filter_transposed_df2_defines.svh"

module iir_tdf2_dp #(
   parameter int TAPS = 3
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_wr_en,
   input  logic [iir_tdf2_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [iir_tdf2_pkg::COEF_BITS-1:0]        csr_wdata,
   input  iir_tdf2_pkg::req_type                     req_data,
   input  iir_tdf2_pkg::dp_cmd_type                  cmd,
   output iir_tdf2_pkg::dp_status_type               status,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output iir_tdf2_pkg::rsp_type                     rsp_data
);
   import iir_tdf2_pkg::*;

   localparam int NumDelay = TAPS - 1;
   localparam int YWidth   = ACC_BITS - COEF_FRAC_BITS;
   localparam logic signed [ACC_BITS-1:0] RoundInc = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [SAMPLE_BITS-1:0] SatMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SatMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [DELAY_BITS-1:0]  DelayMax = {1'b0, {(DELAY_BITS-1){1'b1}}};
   localparam logic signed [DELAY_BITS-1:0]  DelayMin = {1'b1, {(DELAY_BITS-1){1'b0}}};

   logic signed [COEF_BITS-1:0]   coef_b0_ff, coef_b1_ff, coef_b2_ff, coef_a1_ff, coef_a2_ff;
   logic signed [COEF_BITS-1:0]   coef_sel;
   logic signed [SAMPLE_BITS-1:0] x_ff, y_ff, mul_opnd, y_next;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]    acc_ff, round_sum, diff;
   logic signed [YWidth-1:0]      y_wide;
   logic [YWidth-SAMPLE_BITS:0]   y_hi;
   logic                          y_clip;
   logic [ACC_BITS-DELAY_BITS:0]  d_hi;
   logic signed [DELAY_BITS-1:0]  carry, z_next;
   logic signed [DELAY_BITS-1:0]  z_ff [NumDelay];
   logic                          rsp_valid_ff;
   rsp_type                       rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff <= COEF_ONE;
         coef_b1_ff <= '0;
         coef_b2_ff <= '0;
         coef_a1_ff <= '0;
         coef_a2_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            CSR_COEF_B0: coef_b0_ff <= $signed(csr_wdata);
            CSR_COEF_B1: coef_b1_ff <= $signed(csr_wdata);
            CSR_COEF_B2: coef_b2_ff <= $signed(csr_wdata);
            CSR_COEF_A1: coef_a1_ff <= $signed(csr_wdata);
            CSR_COEF_A2: coef_a2_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // coefficients past the programmable ones read as zero
   always_comb begin
      coef_sel = '0;
      if (cmd.mul_fb) begin
         case (cmd.coef_idx)
            2'd1:    coef_sel = coef_a1_ff;
            2'd2:    coef_sel = coef_a2_ff;
            default: coef_sel = '0;
         endcase
      end else begin
         case (cmd.coef_idx)
            2'd0:    coef_sel = coef_b0_ff;
            2'd1:    coef_sel = coef_b1_ff;
            2'd2:    coef_sel = coef_b2_ff;
            default: coef_sel = '0;
         endcase
      end
   end

   assign mul_opnd = cmd.mul_fb ? y_ff : x_ff;
   assign prod_in  = coef_sel * mul_opnd;

   // output rounding and saturation
   assign round_sum = ACC_BITS'(prod_ff) + ACC_BITS'(z_ff[0]) + RoundInc;
   assign y_wide    = round_sum[ACC_BITS-1:COEF_FRAC_BITS];
   assign y_hi      = y_wide[YWidth-1:SAMPLE_BITS-1];
   assign y_clip    = !((&y_hi) || !(|y_hi));
   assign y_next    = y_clip ? (y_wide[YWidth-1] ? SatMin : SatMax) : y_wide[SAMPLE_BITS-1:0];

   always_comb begin
      carry = '0;
      for (int i = 1; i < NumDelay; i++) begin
         if (TAP_IDX_BITS'(i) == cmd.tap_idx + TAP_IDX_BITS'(1)) begin
            carry = z_ff[i];
         end
      end
   end

   // delay word update with saturation
   assign diff   = acc_ff - ACC_BITS'(prod_ff);
   assign d_hi   = diff[ACC_BITS-1:DELAY_BITS-1];
   assign z_next = ((&d_hi) || !(|d_hi)) ? diff[DELAY_BITS-1:0] :
                   (diff[ACC_BITS-1] ? DelayMin : DelayMax);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= req_data.sample_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc_load) begin
         acc_ff <= ACC_BITS'(carry) + ACC_BITS'(prod_ff);
      end
      if (cmd.push) begin
         y_ff                   <= y_next;
         rsp_data_ff.sample_out <= y_next;
         rsp_data_ff.clipped    <= y_clip;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NumDelay; i++) begin
         if (reset) begin
            z_ff[i] <= '0;
         end else if (cmd.load && req_data.op == OP_PRELOAD &&
                      req_data.slot == TAP_IDX_BITS'(i)) begin
            z_ff[i] <= req_data.preload_value;
         end else if (cmd.tap_write && cmd.tap_idx == TAP_IDX_BITS'(i)) begin
            z_ff[i] <= z_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

   `IIR_ASSERT(a_push_when_free, clock, reset, cmd.push |-> !(rsp_valid_ff && rsp_stall))
   `IIR_ASSERT_NEXT(a_push_feedback, clock, reset, cmd.push, rsp_valid_ff && y_ff == rsp_data_ff.sample_out)
   `IIR_ASSERT(a_clip_saturates, clock, reset, (rsp_valid_ff && rsp_data_ff.clipped) |-> (rsp_data_ff.sample_out == SatMax || rsp_data_ff.sample_out == SatMin))

endmodule

// ----- rtl/iir_filter_transposed_df2.sv -----
// a sample request's response is registered in the accumulate state, which follows the multiply
// state and waits while the previous response is stalled; an add and a subtract state per delay
// word follow on the single shared 18x16 multiplier, and no new request is taken until idle again
// a preload request writes the delay word named by its slot and gives no result
// reset (synchronous): delay words cleared, b0 = 1.0, other coefficients zero, no result pending
module iir_filter_transposed_df2 #(
   parameter int TAPS = 3
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_wr_en,
   input  logic [iir_tdf2_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [iir_tdf2_pkg::COEF_BITS-1:0]      csr_wdata,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  iir_tdf2_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output iir_tdf2_pkg::rsp_type                   rsp_data
);
   import iir_tdf2_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   iir_tdf2_ctrl #(
      .TAPS(TAPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   iir_tdf2_dp #(
      .TAPS(TAPS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
